>>> hw/rtl/array_binary_tree_engine_top_defines.svh
// Assertion macros for the binary tree engine checker
`ifndef ARRAY_BINARY_TREE_ENGINE_TOP_DEFINES_SVH
`define ARRAY_BINARY_TREE_ENGINE_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define ABT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset
`define ABT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> hw/rtl/abt_pkg.sv
// Package: types, codes and helpers of the binary tree engine
package abt_pkg;
	localparam int CAPACITY_DEF    = 64;
	localparam int STACK_DEPTH_DEF = 16;

	localparam logic [2:0] OP_PUSH   = 3'd0;
	localparam logic [2:0] OP_SEARCH = 3'd1;
	localparam logic [2:0] OP_LEVEL  = 3'd2;
	localparam logic [2:0] OP_PRE    = 3'd3;
	localparam logic [2:0] OP_IN     = 3'd4;
	localparam logic [2:0] OP_POST   = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] key_value;
		logic [5:0]         start_index;
	} op_item_t;

	typedef struct packed {
		logic signed [31:0] node_value;
		logic [5:0]         node_index;
		logic [2:0]         node_level;
		logic [6:0]         node_count;
		logic [1:0]         status;
		logic               last;
	} result_item_t;

	// depth of heap index: floor(log2(idx+1))
	function automatic logic [2:0] depth_of(input logic [5:0] idx);
		logic [6:0] v;
		logic [2:0] d;
		v = {1'b0, idx} + 7'd1;
		d = 3'd0;
		for (int b = 1; b < 7; b++) begin
			if (v[b]) d = 3'(b);
		end
		return d;
	endfunction
endpackage

>>> hw/rtl/abt_stream_if.sv
// Valid/ready stream interface carrying one payload beat
interface abt_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/array_binary_tree_engine_top.sv
// Top level: heap-order binary tree store with search and traversal sequencer
// Usage:
//  op_in carries one operation beat (push, search, level, pre/in/postorder);
//  res_out carries result beats, the final one of each operation has last set.
//  op_in.ready is high only when the sequencer is idle; one operation is
//  worked on at a time.
//  Push and full-store push present one result in the cycle after acceptance.
//  Search and level scan the store one entry at a time, S_SCAN reading and
//  S_EMIT comparing; a match at index i or, past the count, a miss is presented.
//  Traversals run a walk stack; each step reads one store entry through the
//  single memory read port in two states (S_RD reads, then S_WALK walks).
//  Postorder on 64 nodes takes three steps per node, 192 steps; inorder two
//  steps per node, preorder one.
//  Reset clears the count, stack pointer and sequencer; stored values are
//  undefined until pushed, and never used before then.
//  When the receiver stalls, the result register holds and the walk waits.
//  Undefined operation codes are accepted and dropped without a result.
module array_binary_tree_engine_top #(
	parameter int CAPACITY    = abt_pkg::CAPACITY_DEF,
	parameter int STACK_DEPTH = abt_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	abt_stream_if.sink   op_in,
	abt_stream_if.source res_out
);
	import abt_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SW = $clog2(STACK_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;

	logic [2:0]  state_q;
	logic [2:0]  op_q;
	logic [31:0] key_q;
	logic [6:0]  count_q;
	logic [6:0]  ptr_q;
	logic [SW:0] sp_q;
	logic [IW-1:0] stk_q [STACK_DEPTH];
	logic [1:0]    mark_q [STACK_DEPTH];
	logic [31:0] mem [CAPACITY];
	logic [31:0] rd_q;
	logic        out_valid_q;
	result_item_t out_q;

	// one slot per stack level holds the node and its visit mark
	logic [IW-1:0] top_idx;
	logic [1:0]    top_mark;
	logic [7:0]    lchild, rchild;
	logic          l_ok, r_ok;
	logic          out_free;
	assign top_idx  = stk_q[sp_q[SW-1:0] - SW'(1)];
	assign top_mark = mark_q[sp_q[SW-1:0] - SW'(1)];
	assign lchild   = {1'b0, 6'(top_idx), 1'b1};
	assign rchild   = {1'b0, 6'(top_idx), 1'b0} + 8'd2;
	assign l_ok     = lchild < {1'b0, count_q};
	assign r_ok     = rchild < {1'b0, count_q};
	assign out_free = !out_valid_q || res_out.ready;

	assign op_in.ready     = (state_q == S_IDLE) && out_free;
	assign res_out.valid   = out_valid_q;
	assign res_out.payload = out_q;

	// store write and registered read
	always_ff @(posedge clk) begin
		if (op_in.valid && op_in.ready && op_in.payload.operation == OP_PUSH
				&& count_q < 7'(CAPACITY))
			mem[count_q[IW-1:0]] <= op_in.payload.key_value;
		rd_q <= mem[(state_q == S_SCAN) ? ptr_q[IW-1:0] : top_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic load_out;
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
			ptr_q       <= '0;
			op_q        <= '0;
			key_q       <= '0;
		end else begin
			load_out = 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (op_in.valid && op_in.ready) begin
						op_q  <= op_in.payload.operation;
						key_q <= op_in.payload.key_value;
						ptr_q <= '0;
						if (op_in.payload.operation == OP_PUSH) begin
							load_out = 1'b1;
							if (count_q >= 7'(CAPACITY)) begin
								out_q <= '{32'sd0, 6'd0, 3'd0, count_q, ST_FULL, 1'b1};
							end else begin
								out_q <= '{op_in.payload.key_value, 6'(count_q),
									depth_of(6'(count_q)), count_q + 7'd1, ST_OK, 1'b1};
								count_q <= count_q + 7'd1;
							end
						end else if (op_in.payload.operation == OP_SEARCH
								|| op_in.payload.operation == OP_LEVEL) begin
							state_q <= S_SCAN;
						end else if (op_in.payload.operation == OP_PRE
								|| op_in.payload.operation == OP_IN
								|| op_in.payload.operation == OP_POST) begin
							if ({1'b0, op_in.payload.start_index} >= count_q) begin
								load_out = 1'b1;
								out_q <= '{32'sd0, 6'd0, 3'd0, count_q, ST_EMPTY, 1'b1};
							end else begin
								stk_q[0]  <= op_in.payload.start_index[IW-1:0];
								mark_q[0] <= 2'd0;
								sp_q      <= (SW+1)'(1);
								state_q   <= S_RD;
							end
						end
					end
				end
				// one compare per entry, S_SCAN reads and S_EMIT compares; read data is registered from the pointer
				S_SCAN: begin
					if (ptr_q >= count_q) begin
						if (out_free) begin
							load_out = 1'b1;
							out_q <= '{32'sd0, 6'd0, 3'd0, count_q, ST_NOTFOUND, 1'b1};
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (rd_q == key_q) begin
						if (out_free) begin
							load_out = 1'b1;
							out_q <= '{rd_q, 6'(ptr_q), depth_of(6'(ptr_q)), count_q,
								ST_OK, 1'b1};
							state_q <= S_IDLE;
						end
					end else begin
						ptr_q   <= ptr_q + 7'd1;
						state_q <= S_SCAN;
					end
				end
				// wait for the registered read of the top node's value
				S_RD: state_q <= S_WALK;
				S_WALK: begin
					if (out_free) begin
						logic do_emit;
						logic [SW:0] nsp;
						do_emit = (op_q == OP_PRE) || (top_mark == 2'd2)
							|| (op_q == OP_IN && top_mark == 2'd1);
						nsp = sp_q;
						if (do_emit) begin
							nsp = sp_q - (SW+1)'(1);
						end else begin
							mark_q[sp_q[SW-1:0] - SW'(1)] <= top_mark + 2'd1;
						end
						if (op_q == OP_PRE) begin
							// push right then left, left on top
							if (r_ok && l_ok) begin
								stk_q[nsp[SW-1:0]]          <= rchild[IW-1:0];
								stk_q[nsp[SW-1:0] + SW'(1)] <= lchild[IW-1:0];
								nsp = nsp + (SW+1)'(2);
							end else if (l_ok) begin
								stk_q[nsp[SW-1:0]] <= lchild[IW-1:0];
								nsp = nsp + (SW+1)'(1);
							end
						end else if (top_mark == 2'd0 && l_ok) begin
							stk_q[nsp[SW-1:0]]  <= lchild[IW-1:0];
							mark_q[nsp[SW-1:0]] <= 2'd0;
							nsp = nsp + (SW+1)'(1);
						end else if (top_mark == 2'd1 && r_ok) begin
							stk_q[nsp[SW-1:0]]  <= rchild[IW-1:0];
							mark_q[nsp[SW-1:0]] <= 2'd0;
							nsp = nsp + (SW+1)'(1);
						end
						if (op_q == OP_PRE) begin
							mark_q[nsp[SW-1:0] - SW'(1)] <= 2'd0;
							if (r_ok && l_ok) mark_q[nsp[SW-1:0] - SW'(2)] <= 2'd0;
						end
						sp_q <= nsp;
						// present the node; last once the walk stack runs dry
						if (do_emit) begin
							load_out = 1'b1;
							out_q <= '{rd_q, 6'(top_idx), depth_of(6'(top_idx)), count_q,
								ST_OK, (nsp == '0)};
						end
						if (do_emit && nsp == '0) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// hold the beat until taken, load a new one when offered
			out_valid_q <= load_out || (out_valid_q && !res_out.ready);
		end
	end
endmodule

>>> hw/rtl/abt_checker.sv
// Port checker for the binary tree engine, bound to the top level
`include "array_binary_tree_engine_top_defines.svh"
module abt_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input abt_pkg::result_item_t out_payload
);
	import abt_pkg::*;
	`ABT_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_payload), "result beat changed under stall")
	`ABT_ASSERT_IMPL(a_cnt, clk, arst_n, out_valid, out_payload.node_count <= 7'(CAPACITY_DEF), "count beyond capacity")
	`ABT_ASSERT_IMPL(a_full, clk, arst_n, out_valid && out_payload.status == ST_FULL, out_payload.last, "full status without last")
	`ABT_ASSERT_IMPL(a_busy, clk, arst_n, out_valid && !out_payload.last, !in_ready, "input taken mid traversal")
endmodule

bind array_binary_tree_engine_top abt_checker u_abt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (op_in.ready),
	.out_valid  (res_out.valid),
	.out_ready  (res_out.ready),
	.out_payload(res_out.payload)
);
